/* rtl/mcpt_pkg.sv */
`timescale 1ns / 1ps

package mcpt_pkg;

    // Default configuration of the tracker.
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Widths fixed by the stream fields.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 14;
    localparam int OUT_CNT_W = 16;
    localparam int RUN_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    // Command codes carried in the input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK        = 3'd0,
        CMD_RX_START    = 3'd1,
        CMD_RX_STOP     = 3'd2,
        CMD_LOCAL_START = 3'd3,
        CMD_LOCAL_STOP  = 3'd4,
        CMD_PAUSE       = 3'd5,
        CMD_SET_POS     = 3'd6
    } cmd_t;

    // Transport codes as shown on the result word.
    localparam logic [RUN_W-1:0] RUN_PAUSED   = 2'd0;
    localparam logic [RUN_W-1:0] RUN_STARTING = 2'd1;
    localparam logic [RUN_W-1:0] RUN_STARTED  = 2'd2;

    // Clock mode codes.
    localparam logic [1:0] MODE_INTERNAL = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 1'd1;

    // MIDI real-time and system bytes.
    localparam logic [BYTE_W-1:0] MIDI_CLOCK    = 8'hF8;
    localparam logic [BYTE_W-1:0] START_BYTE    = 8'hFA;
    localparam logic [BYTE_W-1:0] STOP_BYTE     = 8'hFC;
    localparam logic [BYTE_W-1:0] MIDI_SONG_POS = 8'hF2;

    // Status shared by all words produced for one input item.
    typedef struct packed {
        logic                 led_on;
        logic                 step16_event;
        logic                 step32_event;
        logic [OUT_CNT_W-1:0] count96;
        logic [OUT_CNT_W-1:0] count32;
        logic [OUT_CNT_W-1:0] count16;
        logic [RUN_W-1:0]     run_state;
    } status_t;

    // One classified item as handed from the front to the back.
    typedef struct packed {
        status_t                status;
        logic [1:0]             nbytes;
        logic [2:0][BYTE_W-1:0] bytes;
    } job_t;

endpackage

/* rtl/midi_clock_position_tracker.sv */
`timescale 1ns / 1ps

// MIDI beat-clock position tracker.
// Input words on s_t* carry a command (tick, received start or stop, local
// start or stop, pause toggle, set song position) and a song position.
// Each command may update the transport state and the 96th, 32nd and 16th
// counters, and yields one output word, or one word per echoed MIDI byte
// (F8, FA, FC, or F2 lsb msb) when echo is enabled; m_tlast marks the final
// word of a command and m_tuser flags that the byte field is valid.
// The cfg_* port writes clock_mode (index 0) and echo_enable (index 1); it
// is always ready and is meant to be used only while the block is idle.
// The first output word passes through a queue slot and then the output
// register. Throughput: one command per cycle when it gives a single word
// and the receiver is ready; a command with k echoed bytes occupies the output
// for one word per byte, the output register being the limiting resource.
// A small queue between the command decoder and the output sequencer lets
// input words keep flowing while the receiver stalls; s_tready drops only
// when that queue is full. Reset (aresetn low, synchronous) pauses the
// transport, clears counters, phase, LED and registers, and empties the queue.
module midi_clock_position_tracker
    import mcpt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Command input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // command[2:0], position[16:3], zero pad
    // Result output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tx_byte[7:0], led_on[8], step16_event[9], step32_event[10],
    // count96[26:11], count32[42:27], count16[58:43], run_state[60:59], zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser   // tx_valid[0]
);

    logic [1:0]        clock_mode_reg;
    logic              echo_enable_reg;
    logic              push, full, empty, pop;
    job_t              push_job, head;
    status_t           out_status;
    logic              out_tx_valid;
    logic [BYTE_W-1:0] out_tx_byte;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_mode_reg  <= 2'd0;
            echo_enable_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_CLOCK_MODE) begin
                clock_mode_reg <= cfg_data;
            end
            if (cfg_index == REG_ECHO_ENABLE) begin
                echo_enable_reg <= cfg_data[0];
            end
        end
    end

    assign s_tready = !full;

    mcpt_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clock_mode  (clock_mode_reg),
        .echo_enable (echo_enable_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .command     (s_tdata[CMD_W-1:0]),
        .position    (s_tdata[CMD_W+POS_W-1:CMD_W]),
        .push        (push),
        .job         (push_job)
    );

    mcpt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    mcpt_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_tx_valid (out_tx_valid),
        .out_tx_byte  (out_tx_byte),
        .out_last     (m_tlast)
    );

    // Pack the result word, first field in the lowest bits.
    assign m_tuser = out_tx_valid;
    assign m_tdata = {3'd0,
                      out_status.run_state,
                      out_status.count16,
                      out_status.count32,
                      out_status.count96,
                      out_status.step32_event,
                      out_status.step16_event,
                      out_status.led_on,
                      out_tx_byte};

endmodule

/* rtl/mcpt_front.sv */
`timescale 1ns / 1ps

module mcpt_front
    import mcpt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       clock_mode,
    input  logic             echo_enable,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [CMD_W-1:0] command,
    input  logic [POS_W-1:0] position,
    output logic             push,
    output job_t             job
);

    localparam int XW = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;
    // Reciprocal of three scaled by 2^17, exact for every 14-bit position.
    localparam int RECIP3_SHIFT = 17;
    localparam logic [RECIP3_SHIFT-1:0] RECIP3 = 17'd43691;
    localparam int PROD_W = POS_W + RECIP3_SHIFT;

    logic [2:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] c96_reg, c96_next;
    logic [COUNT_WIDTH-1:0] c32_reg, c32_next;
    logic [COUNT_WIDTH-1:0] c16_reg, c16_next;
    logic                   led_reg, led_next;
    logic [RUN_W-1:0]       run_reg, run_next;

    logic [PROD_W-1:0] prod3;
    logic [POS_W-1:0]  quot3;
    logic [POS_W-1:0]  quot6;
    logic [POS_W-1:0]  rem6_full;
    logic              ev16, ev32;
    logic [1:0]        nbytes;
    logic [2:0][BYTE_W-1:0] bytes;
    logic              internal;
    logic [XW-1:0]     c96_x, c32_x, c16_x;

    assign push     = in_valid && in_ready;
    assign internal = (clock_mode == MODE_INTERNAL);

    // Song position split into 32nd, 16th and phase by constant division.
    assign prod3     = PROD_W'(position) * PROD_W'(RECIP3);
    assign quot3     = prod3[PROD_W-1:RECIP3_SHIFT];
    assign quot6     = quot3 >> 1;
    assign rem6_full = position - ((quot6 << 2) + (quot6 << 1));

    // Next transport state, counters and echoed bytes for the incoming command.
    always_comb begin
        phase_next = phase_reg;
        c96_next   = c96_reg;
        c32_next   = c32_reg;
        c16_next   = c16_reg;
        led_next   = led_reg;
        run_next   = run_reg;
        ev16       = 1'b0;
        ev32       = 1'b0;
        nbytes     = 2'd0;
        bytes      = '0;
        unique case (cmd_t'(command))
            CMD_TICK: begin
                bytes[0] = MIDI_CLOCK;
                nbytes   = 2'd1;
                if (phase_reg == 3'd5) begin
                    c16_next = c16_reg + COUNT_WIDTH'(1);
                end
                if (phase_reg == 3'd5 || phase_reg == 3'd2) begin
                    c32_next = c32_reg + COUNT_WIDTH'(1);
                end
                led_next   = (c16_next[1:0] == 2'd0);
                c96_next   = c96_reg + COUNT_WIDTH'(1);
                phase_next = (phase_reg == 3'd5) ? 3'd0 : phase_reg + 3'd1;
                if (run_reg == RUN_STARTING && c96_next != '0) begin
                    run_next = RUN_STARTED;
                end
                ev16 = (phase_reg == 3'd0);
                ev32 = (phase_reg == 3'd0 || phase_reg == 3'd3);
            end
            CMD_RX_START: begin
                bytes[0]   = START_BYTE;
                nbytes     = 2'd1;
                phase_next = 3'd0;
                c96_next   = '0;
                c32_next   = '0;
                c16_next   = '0;
                run_next   = RUN_STARTING;
            end
            CMD_RX_STOP: begin
                bytes[0] = STOP_BYTE;
                nbytes   = 2'd1;
                run_next = RUN_PAUSED;
            end
            CMD_LOCAL_START, CMD_LOCAL_STOP, CMD_PAUSE: begin
                if (internal) begin
                    nbytes = 2'd1;
                    if (cmd_t'(command) == CMD_LOCAL_START ||
                        (cmd_t'(command) == CMD_PAUSE && run_reg == RUN_PAUSED)) begin
                        bytes[0]   = START_BYTE;
                        phase_next = 3'd0;
                        c96_next   = '0;
                        c32_next   = '0;
                        c16_next   = '0;
                        run_next   = RUN_STARTED;
                    end else begin
                        bytes[0] = STOP_BYTE;
                        run_next = RUN_PAUSED;
                    end
                end
            end
            CMD_SET_POS: begin
                c96_next   = COUNT_WIDTH'(position);
                c32_next   = COUNT_WIDTH'(quot3);
                c16_next   = COUNT_WIDTH'(quot6);
                phase_next = rem6_full[2:0];
                bytes[0]   = MIDI_SONG_POS;
                bytes[1]   = {1'b0, position[6:0]};
                bytes[2]   = {1'b0, position[13:7]};
                nbytes     = 2'd3;
            end
            default: begin
            end
        endcase
        // With echo off every item yields one word without a byte.
        if (!echo_enable) begin
            nbytes = 2'd0;
        end
    end

    // Counters are shown as their low 16 bits.
    assign c96_x = XW'(c96_next);
    assign c32_x = XW'(c32_next);
    assign c16_x = XW'(c16_next);

    always_comb begin
        job.status.led_on       = led_next;
        job.status.step16_event = ev16;
        job.status.step32_event = ev32;
        job.status.count96      = c96_x[OUT_CNT_W-1:0];
        job.status.count32      = c32_x[OUT_CNT_W-1:0];
        job.status.count16      = c16_x[OUT_CNT_W-1:0];
        job.status.run_state    = run_next;
        job.nbytes              = nbytes;
        job.bytes               = bytes;
    end

    // Tracker state advances on each accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 3'd0;
            c96_reg   <= '0;
            c32_reg   <= '0;
            c16_reg   <= '0;
            led_reg   <= 1'b0;
            run_reg   <= RUN_PAUSED;
        end else if (push) begin
            phase_reg <= phase_next;
            c96_reg   <= c96_next;
            c32_reg   <= c32_next;
            c16_reg   <= c16_next;
            led_reg   <= led_next;
            run_reg   <= run_next;
        end
    end

endmodule

/* rtl/mcpt_queue.sv */
`timescale 1ns / 1ps

module mcpt_queue
    import mcpt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    job_t            slots [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   fill_reg, fill_next;

    assign full  = (fill_reg == NW'(DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = slots[rd_ptr_reg];

    // Pointer wrap and fill level.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + NW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/mcpt_back.sv */
`timescale 1ns / 1ps

module mcpt_back
    import mcpt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              empty,
    input  job_t              head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output status_t           out_status,
    output logic              out_tx_valid,
    output logic [BYTE_W-1:0] out_tx_byte,
    output logic              out_last
);

    logic [1:0]        idx_reg, idx_next;
    logic              valid_reg, valid_next;
    status_t           status_reg;
    logic              tx_valid_reg;
    logic [BYTE_W-1:0] tx_byte_reg;
    logic              last_reg;
    logic              load;
    logic [1:0]        nwords;
    logic              last_word;

    assign load      = !valid_reg || out_ready;
    assign nwords    = (head.nbytes == 2'd0) ? 2'd1 : head.nbytes;
    assign last_word = (idx_reg == nwords - 2'd1);
    assign pop       = load && !empty && last_word;

    // Walk through the bytes of the head item, one word per free output slot.
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = !empty;
            if (!empty) begin
                idx_next = last_word ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (load && !empty) begin
            status_reg   <= head.status;
            tx_valid_reg <= (head.nbytes != 2'd0);
            tx_byte_reg  <= (head.nbytes != 2'd0) ? head.bytes[idx_reg] : '0;
            last_reg     <= last_word;
        end
    end

    assign out_valid    = valid_reg;
    assign out_status   = status_reg;
    assign out_tx_valid = tx_valid_reg;
    assign out_tx_byte  = tx_byte_reg;
    assign out_last     = last_reg;

endmodule

/* rtl/mcpt_checker.sv */
`timescale 1ns / 1ps

module mcpt_checker
    import mcpt_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast,
    input logic                m_tuser
);

    // A stalled result word must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A word without a byte is the only word of its command.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("byte-less word is not a lone final word");

    // A new 16th step always begins a new 32nd step.
    a_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[10])
        else $error("16th step event without 32nd step event");

    // The transport never shows the unused code.
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[60:59] != 2'd3)
        else $error("invalid transport state on output");

endmodule

bind midi_clock_position_tracker mcpt_checker u_mcpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
